### rtl/mie_pkg.sv
package mie_pkg;

    // fixed field widths of the channels and the configuration register
    localparam int VALUE_WIDTH   = 32;
    localparam int MODULUS_WIDTH = 31;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic [MODULUS_WIDTH-1:0]      modulus_t;

    // modulus after reset
    localparam modulus_t MODULUS_RESET = modulus_t'(2);

endpackage

### rtl/mie_if.sv
// input channel: one value to invert per beat
interface mie_in_if;
    import mie_pkg::*;

    logic   valid;
    logic   ready;
    value_t value_in;

    modport source (output valid, output value_in, input ready);
    modport sink   (input valid, input value_in, output ready);
endinterface

// output channel: inverse and gcd per beat
interface mie_out_if;
    import mie_pkg::*;

    logic   valid;
    logic   ready;
    value_t inverse_out;
    value_t gcd_out;

    modport source (output valid, output inverse_out, output gcd_out, input ready);
    modport sink   (input valid, input inverse_out, input gcd_out, output ready);
endinterface

### rtl/modular_inverse_ext_euclid.sv
// Modular inverse by the extended Euclidean algorithm.
// in_ch carries a signed value_in; out_ch returns inverse_out (Bezout coefficient,
// made nonnegative once by adding the modulus) and gcd_out (final remainder; a value
// of 1 means the inverse is valid). The modulus is written through cfg_we/cfg_data
// and must only change while no item is in flight.
// in_ch.ready is high only while the sequencer is idle, so one item is worked at a time.
// Each Euclid step runs one zero test, the shared restoring divider (which also
// accumulates |q| * s1 by shift and add) and one update. Inputs of 1 or -1 skip
// the steps and go straight to the result. For 32-bit operands an item needs at
// most about 46 steps.
// The finished result sits in an output register; the sequencer returns to idle and
// accepts the next item while that beat waits. If the next result finishes before the
// receiver takes the pending beat, the sequencer holds it until out_ch.ready.
// Reset (rst_n low, asynchronous) empties the output register, returns the sequencer
// to idle and sets the modulus to 2.
module modular_inverse_ext_euclid #(
    parameter int WORD_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    mie_in_if.sink            in_ch,
    mie_out_if.source         out_ch,
    input  logic              cfg_we,
    input  mie_pkg::modulus_t cfg_data
);
    import mie_pkg::*;

    localparam int CNT_W = $clog2(WORD_WIDTH);

    typedef logic signed [WORD_WIDTH-1:0] word_t;
    typedef logic [WORD_WIDTH-1:0]        uword_t;

    localparam word_t ONE       = word_t'(1);
    localparam word_t MINUS_ONE = word_t'(-1);
    localparam word_t ZERO      = word_t'(0);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_WIDTH - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_UPD   = 3'd3;
    localparam logic [2:0] ST_FIXG  = 3'd4;
    localparam logic [2:0] ST_FIXS  = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    modulus_t         modulus_reg;

    word_t  r0_reg, r0_next, r1_reg, r1_next;
    word_t  s0_reg, s0_next, s1_reg, s1_next;
    uword_t rem_reg, rem_next, quo_reg, quo_next, dvs_reg, dvs_next;
    word_t  acc_reg, acc_next;
    value_t inv_out_reg, inv_out_next, gcd_out_reg, gcd_out_next;

    word_t             a_w, p_w;
    logic              in_fire, out_free, q_neg, ge;
    logic [WORD_WIDTH:0] shifted;

    assign in_ch.ready        = (state_reg == ST_IDLE);
    assign in_fire            = in_ch.valid && in_ch.ready;
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.inverse_out = inv_out_reg;
    assign out_ch.gcd_out     = gcd_out_reg;
    assign out_free           = !out_valid_reg || out_ch.ready;

    // operands taken to the working width
    assign a_w = word_t'(in_ch.value_in);
    assign p_w = word_t'(modulus_reg);

    // shared divider step: shift in next dividend bit, trial subtract
    assign shifted = {rem_reg, quo_reg[WORD_WIDTH-1]};
    assign ge      = (shifted >= {1'b0, dvs_reg});
    assign q_neg   = r0_reg[WORD_WIDTH-1] ^ r1_reg[WORD_WIDTH-1];

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        r0_next        = r0_reg;
        r1_next        = r1_reg;
        s0_next        = s0_reg;
        s1_next        = s1_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        dvs_next       = dvs_reg;
        acc_next       = acc_reg;
        inv_out_next   = inv_out_reg;
        gcd_out_next   = gcd_out_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (a_w == ONE || a_w == MINUS_ONE)
                    begin
                        // unit input passes through with gcd 1
                        r0_next    = ONE;
                        s0_next    = a_w;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        r0_next    = a_w;
                        r1_next    = p_w;
                        s0_next    = ONE;
                        s1_next    = ZERO;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (r1_reg == ZERO)
                begin
                    state_next = ST_FIXG;
                end
                else
                begin
                    // load divider with magnitudes
                    rem_next   = '0;
                    quo_next   = r0_reg[WORD_WIDTH-1] ? uword_t'(-r0_reg) : uword_t'(r0_reg);
                    dvs_next   = r1_reg[WORD_WIDTH-1] ? uword_t'(-r1_reg) : uword_t'(r1_reg);
                    acc_next   = ZERO;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // one quotient bit; Horner accumulation of |q| * s1
                rem_next = ge ? uword_t'(shifted - {1'b0, dvs_reg}) : uword_t'(shifted);
                quo_next = {quo_reg[WORD_WIDTH-2:0], ge};
                acc_next = word_t'({acc_reg[WORD_WIDTH-2:0], 1'b0}) + (ge ? s1_reg : ZERO);
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_UPD;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_UPD:
            begin
                // remainder takes the dividend sign, coefficient s0 - q * s1
                r0_next    = r1_reg;
                s0_next    = s1_reg;
                r1_next    = r0_reg[WORD_WIDTH-1] ? -word_t'(rem_reg) : word_t'(rem_reg);
                s1_next    = q_neg ? (s0_reg + acc_reg) : (s0_reg - acc_reg);
                state_next = ST_CHECK;
            end
            ST_FIXG:
            begin
                // gcd of -1: negate gcd and coefficient
                if (r0_reg == MINUS_ONE)
                begin
                    r0_next = ONE;
                    s0_next = -s0_reg;
                end
                state_next = ST_FIXS;
            end
            ST_FIXS:
            begin
                // negative coefficient gets the modulus added once
                if (s0_reg[WORD_WIDTH-1])
                begin
                    s0_next = s0_reg + p_w;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    inv_out_next   = value_t'(s0_reg);
                    gcd_out_next   = value_t'(r0_reg);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            modulus_reg   <= MODULUS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                modulus_reg <= cfg_data;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        r0_reg      <= r0_next;
        r1_reg      <= r1_next;
        s0_reg      <= s0_next;
        s1_reg      <= s1_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        dvs_reg     <= dvs_next;
        acc_reg     <= acc_next;
        inv_out_reg <= inv_out_next;
        gcd_out_reg <= gcd_out_next;
    end

`ifndef ASSERT_OFF
    // divider never runs on a zero divisor
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (dvs_reg != '0))
        else $error("divider running with zero divisor");

    // partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < dvs_reg))
        else $error("partial remainder not below divisor");

    // an accepted item starts the sequencer
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg != ST_IDLE))
        else $error("accepted item did not start the sequencer");

    // bit counter is clear on every zero test
    a_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK) |-> (cnt_reg == '0))
        else $error("bit counter not clear at step start");
`endif

endmodule

### test/tb_modular_inverse_ext_euclid.sv
`timescale 1ns / 100ps

module tb_modular_inverse_ext_euclid;
    import mie_pkg::*;

    localparam int        CLK_PERIOD   = 12;
    localparam int        RESET_CYCLES = 7;
    localparam int        MAX_LATENCY  = 1600;
    localparam int        BATCHES      = 20;
    localparam int        BATCH_ITEMS  = 20;
    localparam int        MAX_PRINTS   = 40;
    localparam modulus_t  MODULUS_MAX  = modulus_t'(31'h7FFF_FFFF);
    localparam value_t    VALUE_MIN    = value_t'(32'sh8000_0000);
    localparam value_t    VALUE_MAX    = value_t'(32'sh7FFF_FFFF);

    typedef struct {
        value_t inverse;
        value_t gcd;
    } inverse_pair_t;

    logic     clk;
    logic     rst_n;
    logic     cfg_we;
    modulus_t cfg_data;

    mie_in_if  in_ch ();
    mie_out_if out_ch ();

    // predictor state and bookkeeping
    modulus_t      model_modulus;
    inverse_pair_t pending_inverses[$];
    int            tx_idle_pct;
    int            rx_idle_pct;
    int            error_count;
    int            items_sent;
    int            results_seen;
    int            modulus_writes;

    modular_inverse_ext_euclid i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_PERIOD / 2) clk = ~clk;

    // reduce to the 32-bit word and sign-extend
    function automatic longint wrap_word(input longint x);
        logic signed [31:0] w;
        w = x[31:0];
        return longint'(w);
    endfunction

    // extended euclid with truncating division, wrapping at the word width
    function automatic inverse_pair_t compute_inverse(input value_t value,
                                                      input modulus_t modulus);
        inverse_pair_t res;
        longint        r0;
        longint        r1;
        longint        s0;
        longint        s1;
        longint        q;
        longint        nr;
        longint        ns;
        longint        p;
        p = wrap_word(longint'(modulus));
        if (value == 1 || value == -1)
        begin
            res.inverse = value;
            res.gcd     = value_t'(1);
            return res;
        end
        r0 = longint'(value);
        r1 = p;
        s0 = 1;
        s1 = 0;
        while (r1 != 0)
        begin
            q  = r0 / r1;
            nr = wrap_word(r0 - wrap_word(q * r1));
            ns = wrap_word(s0 - wrap_word(q * s1));
            r0 = r1;
            s0 = s1;
            r1 = nr;
            s1 = ns;
        end
        // a gcd of minus one flips the sign of both
        if (r0 == -1)
        begin
            r0 = 1;
            s0 = wrap_word(-s0);
        end
        // negative coefficient is lifted by one modulus
        if (s0 < 0)
            s0 = wrap_word(s0 + p);
        res.inverse = value_t'(s0[31:0]);
        res.gcd     = value_t'(r0[31:0]);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // receiver stalls
    always @(posedge clk)
    begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        inverse_pair_t exp_pair;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_seen++;
            if (pending_inverses.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat inverse=%0d gcd=%0d",
                                          out_ch.inverse_out, out_ch.gcd_out));
            end
            else
            begin
                exp_pair = pending_inverses.pop_front();
                if (out_ch.inverse_out !== exp_pair.inverse)
                    report_mismatch($sformatf("inverse_out got %0d expected %0d",
                                              out_ch.inverse_out, exp_pair.inverse));
                if (out_ch.gcd_out !== exp_pair.gcd)
                    report_mismatch($sformatf("gcd_out got %0d expected %0d",
                                              out_ch.gcd_out, exp_pair.gcd));
            end
        end
    end

    // one input beat, with random gaps before it
    task automatic send_value(input value_t value);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.value_in <= value;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        pending_inverses.push_back(compute_inverse(value, model_modulus));
        items_sent++;
    endtask

    // stop sending and wait for every outstanding result
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_inverses.size() != 0)
            @(posedge clk);
    endtask

    // modulus change only while idle
    task automatic write_modulus(input modulus_t modulus);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= modulus;
        @(posedge clk);
        cfg_we        <= 1'b0;
        model_modulus = modulus;
        modulus_writes++;
    endtask

    task automatic set_idling(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
    endtask

    function automatic value_t random_value(input modulus_t modulus);
        case ($urandom_range(9))
            5:       return value_t'(int'($urandom_range(40)) - 20);
            6:       return value_t'(longint'(modulus) + int'($urandom_range(6)) - 3);
            7:       return ($urandom_range(1) != 0) ? value_t'(1) : value_t'(-1);
            8:       return value_t'(longint'(modulus) * int'($urandom_range(3)));
            9:       return ($urandom_range(1) != 0) ? VALUE_MIN : VALUE_MAX;
            default: return value_t'($urandom);
        endcase
    endfunction

    function automatic modulus_t random_modulus();
        case ($urandom_range(9))
            5:       return modulus_t'($urandom_range(100, 2));
            6:       return MODULUS_MAX;
            7:       return modulus_t'(2);
            8:       return ($urandom_range(1) != 0) ? modulus_t'(65521)
                                                     : modulus_t'(1000000007);
            9:       return modulus_t'($urandom_range(1));
            default: return modulus_t'($urandom);
        endcase
    endfunction

    // reset modulus of two, field extremes and units
    task automatic test_reset_modulus();
        send_value(value_t'(0));
        send_value(value_t'(1));
        send_value(value_t'(-1));
        send_value(value_t'(2));
        send_value(value_t'(3));
        send_value(VALUE_MIN);
        send_value(VALUE_MAX);
    endtask

    // largest modulus, a prime
    task automatic test_max_modulus();
        write_modulus(MODULUS_MAX);
        send_value(value_t'(0));
        send_value(value_t'(2));
        send_value(value_t'(-2));
        send_value(VALUE_MAX);
        send_value(VALUE_MIN);
        send_value(value_t'(32'sh5555_5555));
        send_value(value_t'(32'shAAAA_AAAA));
        send_value(value_t'(1));
        send_value(value_t'(-1));
        send_value(value_t'(12345));
    endtask

    // modulus of zero skips the loop, modulus of one is used as is
    task automatic test_degenerate_moduli();
        write_modulus(modulus_t'(0));
        send_value(value_t'(5));
        send_value(value_t'(-7));
        send_value(value_t'(0));
        write_modulus(modulus_t'(1));
        send_value(value_t'(9));
        send_value(value_t'(-3));
    endtask

    // random batches, each under its own modulus, through the idling patterns
    task automatic test_random_batches();
        int batch;
        int n;
        for (batch = 0; batch < BATCHES; batch++)
        begin
            if (batch < BATCHES / 3)
                set_idling(28, 71);
            else if (batch < 2 * BATCHES / 3)
                set_idling(71, 28);
            else
                set_idling(0, 0);
            write_modulus(random_modulus());
            for (n = 0; n < BATCH_ITEMS; n++)
                send_value(random_value(model_modulus));
        end
    endtask

    // main sequence
    initial
    begin
        error_count    = 0;
        items_sent     = 0;
        results_seen   = 0;
        modulus_writes = 0;
        model_modulus  = MODULUS_RESET;
        set_idling(28, 71);
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_data       <= '0;
        in_ch.valid    <= 1'b0;
        in_ch.value_in <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_modulus();
        test_max_modulus();
        test_degenerate_moduli();
        test_random_batches();

        // drain, then watch for stray beats
        wait_drained();
        repeat (MAX_LATENCY) @(posedge clk);
        while (pending_inverses.size() != 0)
        begin
            void'(pending_inverses.pop_front());
            report_mismatch("expected result never arrived");
        end

        $display("sent %0d values under %0d modulus writes, %0d results checked",
                 items_sent, modulus_writes, results_seen);
        $display("covered units, zero, word extremes, moduli 0/1/2/max, three stall mixes");
        if (error_count == 0)
            $display("** modular_inverse_ext_euclid: PASSED **");
        else
            $display("** modular_inverse_ext_euclid: FAILED **");
        $finish;
    end

    // watchdog
    initial
    begin
        #48_000_000;
        $display("watchdog expired with %0d results outstanding", pending_inverses.size());
        $display("** modular_inverse_ext_euclid: FAILED **");
        $finish;
    end

endmodule
